@@ rtl/smrc_pkg.sv @@
`default_nettype none
package smrc_pkg;

  localparam int LINE_BYTES = 256;
  localparam int TEXT_CAP = ((LINE_BYTES - 1) < 255) ? (LINE_BYTES - 1) : 255;
  localparam int CONTENT_MAX = LINE_BYTES - 2;
  localparam int LBC_W = $clog2(LINE_BYTES);
  localparam int FIXED_LEN = 19;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int RAM_DEPTH = 256;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_FAIL = 2'd2;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_TEXT = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_LINK = 2'd3;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [15:0] MIN_CODE = 16'd100;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_HEAD,
    PH_WS,
    PH_TEXT
  } phase_t;

  typedef struct packed {
    logic [15:0]      code;
    phase_t           phase;
    logic [2:0]       off;
    logic [LBC_W-1:0] lbc;
    logic             cont;
    logic             has_text;
    logic             digits;
    logic [7:0]       lwl;
  } line_t;

  typedef struct packed {
    line_t      ln;
    logic       wr;
    logic [7:0] wdata;
  } cstep_t;

  typedef struct packed {
    logic        from_bytes;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  start;
    logic [4:0]  n;
    logic [4:0]  fix_len;
    logic        has_out;
    logic [1:0]  kind;
    logic [15:0] code;
    logic [7:0]  length;
    logic        rd;
    logic [7:0]  idx;
    logic        rd_ok;
  } cmd_t;

  function automatic logic [7:0] fixed_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0:    c = 8'h4E;
      5'd1:    c = 8'h6F;
      5'd2:    c = 8'h20;
      5'd3:    c = 8'h72;
      5'd4:    c = 8'h65;
      5'd5:    c = 8'h70;
      5'd6:    c = 8'h6C;
      5'd7:    c = 8'h79;
      5'd8:    c = 8'h20;
      5'd9:    c = 8'h74;
      5'd10:   c = 8'h65;
      5'd11:   c = 8'h78;
      5'd12:   c = 8'h74;
      5'd13:   c = 8'h20;
      5'd14:   c = 8'h67;
      5'd15:   c = 8'h69;
      5'd16:   c = 8'h76;
      5'd17:   c = 8'h65;
      5'd18:   c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic line_t cleared_line(input logic [7:0] lwl);
    line_t l;
    l.code = '0;
    l.phase = PH_SKIP;
    l.off = '0;
    l.lbc = '0;
    l.cont = 1'b0;
    l.has_text = 1'b0;
    l.digits = 1'b0;
    l.lwl = lwl;
    return l;
  endfunction

  function automatic cstep_t content_byte(input line_t l, input logic [7:0] b);
    cstep_t r;
    logic [19:0] prod;
    logic store;
    r.ln = l;
    r.wr = 1'b0;
    r.wdata = b;
    store = 1'b0;
    prod = '0;
    if (int'(l.lbc) < CONTENT_MAX) begin
      r.ln.lbc = l.lbc + 1'b1;
      if (l.phase == PH_SKIP) begin
        if (is_digit(b)) begin
          r.ln.code = {12'd0, b[3:0]};
          r.ln.digits = 1'b1;
          r.ln.off = 3'd1;
          r.ln.phase = PH_HEAD;
        end
      end else begin
        if (l.digits && is_digit(b)) begin
          prod = ({4'd0, l.code} << 3) + ({4'd0, l.code} << 1) + {16'd0, b[3:0]};
          r.ln.code = (prod > 20'hFFFF) ? 16'hFFFF : prod[15:0];
        end else begin
          r.ln.digits = 1'b0;
        end
        case (l.phase)
          PH_HEAD: begin
            if (l.off == 3'd3) begin
              if (b == CHAR_DASH) begin
                r.ln.cont = 1'b1;
                r.ln.phase = PH_WS;
              end else begin
                r.ln.phase = PH_TEXT;
                r.ln.has_text = 1'b1;
                store = 1'b1;
              end
            end
          end
          PH_WS: begin
            if (!is_space(b)) begin
              r.ln.phase = PH_TEXT;
              r.ln.has_text = 1'b1;
              store = 1'b1;
            end
          end
          PH_TEXT: store = 1'b1;
          default: ;
        endcase
        if (store && (l.lwl < 8'(TEXT_CAP))) begin
          r.wr = 1'b1;
          r.ln.lwl = l.lwl + 1'b1;
        end
        if (l.off < 3'd4) begin
          r.ln.off = l.off + 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/smrc_if.sv @@
`default_nettype none
interface smrc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [7:0] text_index;
  modport source (output valid, output action, output data_byte, output text_index,
                  input ready);
  modport sink (input valid, input action, input data_byte, input text_index,
                output ready);
endinterface

interface smrc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] reply_code;
  logic [7:0]  text_length;
  logic [7:0]  text_byte;
  modport source (output valid, output kind, output reply_code, output text_length,
                  output text_byte, input ready);
  modport sink (input valid, input kind, input reply_code, input text_length,
                input text_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/smtp_reply_collector.sv @@
// Channel  Modport  Contents
// req      sink     action, data_byte, text_index
// res      source   kind, reply_code, text_length, text_byte
//
// A byte that follows a held CR can write two characters to the text store.
// A line end with an empty first line can write the fixed text and "; " into the store.
// The text store has one write port, so such characters are written one at a time; reads are registered.
// Reset is synchronous and clears all control state; the text store is not cleared.
// A four-entry queue lets the parser keep accepting while the result side is stalled.
`default_nettype none
module smtp_reply_collector (
  input  wire logic  clk,
  input  wire logic  rst,
  smrc_req_if.sink   req,
  smrc_res_if.source res
);
  import smrc_pkg::*;

  logic push, full, pop, head_valid;
  cmd_t push_cmd, head;

  smrc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  smrc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  smrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );
endmodule
`default_nettype wire

@@ rtl/smrc_ram.sv @@
`default_nettype none
module smrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/smrc_front.sv @@
`default_nettype none
module smrc_front (
  input  wire logic    clk,
  input  wire logic    rst,
  smrc_req_if.sink     req,
  output logic         push,
  output smrc_pkg::cmd_t push_cmd,
  input  wire logic    full
);
  import smrc_pkg::*;

  line_t       ln, ln_next;
  logic [7:0]  committed, committed_next;
  logic [15:0] held, held_next;
  logic        awaiting, awaiting_next;
  logic        pend, pend_next;
  logic        reply_held, reply_held_next;

  line_t       l0;
  cstep_t      c1, c2;
  cmd_t        cmd;
  logic [7:0]  cm, w, room, start;
  logic [4:0]  fl;
  logic        sep, done, aw, acc;
  logic [15:0] hc;

  assign req.ready = !full;
  assign acc = req.valid && req.ready;

  always_comb begin
    ln_next = ln;
    committed_next = committed;
    held_next = held;
    awaiting_next = awaiting;
    pend_next = pend;
    reply_held_next = reply_held;
    cmd = '0;
    push = 1'b0;
    l0 = ln;
    cm = committed;
    c1 = '0;
    c2 = '0;
    w = '0;
    room = '0;
    start = '0;
    fl = '0;
    sep = 1'b0;
    done = 1'b0;
    aw = awaiting;
    hc = held;
    if (acc) begin
      case (req.action)
        ACT_BYTE: begin
          if (reply_held) begin
            reply_held_next = 1'b0;
            cm = '0;
            l0.lwl = '0;
          end
          if (req.data_byte == CHAR_LF) begin
            pend_next = 1'b0;
            w = l0.lwl;
            if (awaiting) begin
              if ((l0.code == held) && !l0.cont) begin
                aw = 1'b0;
                cm = l0.lwl;
                done = 1'b1;
              end
            end else begin
              hc = l0.code;
              aw = l0.cont;
              if (!l0.has_text) begin
                room = 8'(TEXT_CAP) - cm;
                fl = (room < 8'(FIXED_LEN)) ? room[4:0] : 5'(FIXED_LEN);
                w = cm + {3'd0, fl};
                start = cm;
              end else begin
                start = w;
              end
              if (w > cm) begin
                cm = w;
                if (aw && (({1'b0, cm} + 9'd3) < 9'(TEXT_CAP))) begin
                  sep = 1'b1;
                  cm = cm + 8'd2;
                end
              end
              done = !aw;
            end
            if (done) begin
              if (hc < MIN_CODE) begin
                cm = '0;
              end else begin
                reply_held_next = 1'b1;
                cmd.has_out = 1'b1;
                cmd.kind = KIND_DONE;
                cmd.code = hc;
                cmd.length = cm;
              end
            end
            cmd.start = start;
            cmd.fix_len = fl;
            cmd.n = fl + (sep ? 5'd2 : 5'd0);
            push = (cmd.n != '0) || cmd.has_out;
            committed_next = cm;
            held_next = hc;
            awaiting_next = aw;
            ln_next = cleared_line(cm);
          end else begin
            pend_next = (req.data_byte == CHAR_CR);
            c1.ln = l0;
            if (pend) begin
              c1 = content_byte(l0, CHAR_CR);
            end
            c2.ln = c1.ln;
            if (req.data_byte != CHAR_CR) begin
              c2 = content_byte(c1.ln, req.data_byte);
            end
            ln_next = c2.ln;
            committed_next = cm;
            cmd.from_bytes = 1'b1;
            cmd.start = c1.wr ? l0.lwl : c1.ln.lwl;
            cmd.d0 = c1.wr ? c1.wdata : c2.wdata;
            cmd.d1 = c2.wdata;
            cmd.n = {4'd0, c1.wr} + {4'd0, c2.wr};
            push = (cmd.n != '0);
          end
        end
        ACT_READ: begin
          push = 1'b1;
          cmd.has_out = 1'b1;
          if (reply_held) begin
            cmd.kind = KIND_TEXT;
            cmd.code = held;
            cmd.length = committed;
            cmd.rd = 1'b1;
            cmd.idx = req.text_index;
            cmd.rd_ok = req.text_index < committed;
          end else begin
            cmd.kind = KIND_NONE;
          end
        end
        ACT_FAIL: begin
          reply_held_next = 1'b0;
          awaiting_next = 1'b0;
          committed_next = '0;
          pend_next = 1'b0;
          ln_next = cleared_line(8'd0);
          push = 1'b1;
          cmd.has_out = 1'b1;
          cmd.kind = KIND_LINK;
        end
        default: ;
      endcase
    end
  end

  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ln <= cleared_line(8'd0);
      committed <= '0;
      held <= '0;
      awaiting <= 1'b0;
      pend <= 1'b0;
      reply_held <= 1'b0;
    end else begin
      ln <= ln_next;
      committed <= committed_next;
      held <= held_next;
      awaiting <= awaiting_next;
      pend <= pend_next;
      reply_held <= reply_held_next;
    end
  end
endmodule
`default_nettype wire

@@ rtl/smrc_cmd_fifo.sv @@
`default_nettype none
module smrc_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire smrc_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output smrc_pkg::cmd_t       head,
  output logic                 head_valid
);
  import smrc_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rp];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("Request pushed into a full queue.");
endmodule
`default_nettype wire

@@ rtl/smrc_back.sv @@
`default_nettype none
module smrc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire smrc_pkg::cmd_t head,
  output logic                pop,
  smrc_res_if.source          res
);
  import smrc_pkg::*;

  logic [4:0]  j;
  logic        last, out_free, s1_ready, fire, we;
  logic [7:0]  waddr, wdata, rdata;
  logic        s1_valid;
  cmd_t        s1;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_code;
  logic [7:0]  out_len, out_byte;

  assign last = (head.n == '0) || (j == (head.n - 5'd1));
  assign out_free = !out_valid || res.ready;
  assign s1_ready = !s1_valid || out_free;
  assign fire = head_valid && last && (!head.has_out || s1_ready);
  assign pop = fire;
  assign we = head_valid && (head.n != '0);
  assign waddr = head.start + {3'd0, j};

  always_comb begin
    if (head.from_bytes) begin
      wdata = (j == '0) ? head.d0 : head.d1;
    end else if (j < head.fix_len) begin
      wdata = fixed_char(j);
    end else if (j == head.fix_len) begin
      wdata = CHAR_SEMI;
    end else begin
      wdata = CHAR_SPACE;
    end
  end

  smrc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_text (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (fire && head.rd),
    .raddr (head.idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        j <= '0;
      end else if (we && !last) begin
        j <= j + 5'd1;
      end
      if (s1_ready) begin
        s1_valid <= fire && head.has_out;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1 <= head;
    end
    if (out_free && s1_valid) begin
      out_kind <= s1.kind;
      out_code <= s1.code;
      out_len <= s1.length;
      out_byte <= (s1.rd && s1.rd_ok) ? rdata : 8'd0;
    end
  end

  assign res.valid = out_valid;
  assign res.kind = out_kind;
  assign res.reply_code = out_code;
  assign res.text_length = out_len;
  assign res.text_byte = out_byte;

  a_write_in_run: assert property (@(posedge clk) disable iff (rst)
    we |-> (j < head.n))
    else $error("Write step beyond the end of its run.");

  a_result_staged: assert property (@(posedge clk) disable iff (rst)
    (fire && head.has_out) |=> s1_valid)
    else $error("Finished request lost its result.");
endmodule
`default_nettype wire
